// File: design/fractional_clock_divider_solver_defines.svh
// ----------------------------------------------------------------------------
// Fractional clock divider solver: assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef FRACTIONAL_CLOCK_DIVIDER_SOLVER_DEFINES_SVH
`define FRACTIONAL_CLOCK_DIVIDER_SOLVER_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define FCDS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("fcds assertion failed");
// condition must never be true outside reset
`define FCDS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `FCDS_ASSERT(lbl, clk, rst_n, !(cond))
`else
`define FCDS_ASSERT(lbl, clk, rst_n, prop)
`define FCDS_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// File: design/fcds_pkg.sv
// ----------------------------------------------------------------------------
// fcds_pkg
// Shared widths, constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package fcds_pkg;

  localparam int unsigned FreqW = 30;
  localparam int unsigned DivW  = 8;
  localparam int unsigned FracW = 6;

  localparam logic [FreqW-1:0] BaseReset = 30'd80000000;
  localparam logic [DivW-1:0]  DivCap    = 8'd255;
  localparam logic [FreqW-1:0] FracSpan  = 30'd63;
  localparam logic [DivW-1:0]  FracMinN  = 8'd4;

  // datapath operations, one per controller step
  typedef enum logic [3:0] {
    OpNop,
    OpLoad,
    OpSetZero,
    OpDivN,
    OpCapN,
    OpEuInit,
    OpEuStep,
    OpGDone,
    OpADone,
    OpBDone,
    OpDDone,
    OpA2Done,
    OpB2Done,
    OpSetTriv,
    OpEmit
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    logic tgt_zero;
    logic n_gt_min;
    logic rem_zero;
    logic div_done;
    logic div_rem_zero;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// File: design/fcds_div.sv
// ----------------------------------------------------------------------------
// fcds_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fcds_div #(
  parameter int unsigned W = fcds_pkg::FreqW
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] dividend_i,
  input  wire logic [W-1:0] divisor_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [W-1:0]      quot_o,
  output logic [W-1:0]      rem_o
);

  localparam int unsigned CntW = (W > 1) ? $clog2(W) : 1;
  localparam logic [CntW-1:0] CntLast = CntW'(W - 1);

  logic [W-1:0]    r_q, r_d, q_q, q_d, dsr_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [W:0]      shifted;
  logic [W+1:0]    diff;
  logic            ge;

  always_comb begin
    shifted = {r_q, q_q[W-1]};
    diff    = {1'b0, shifted} - {2'b00, dsr_q};
    ge      = !diff[W+1];
    r_d     = ge ? diff[W-1:0] : shifted[W-1:0];
    q_d     = {q_q[W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      r_q   <= '0;
      q_q   <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      r_q <= r_d;
      q_q <= q_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = q_q;
  assign rem_o  = r_q;

endmodule

`default_nettype wire

// File: design/fcds_dp.sv
// ----------------------------------------------------------------------------
// fcds_dp
// Datapath: base register, working registers, shared divider, result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "fractional_clock_divider_solver_defines.svh"

module fcds_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  input  wire logic [fcds_pkg::FreqW-1:0]  base_clock_hz_i,
  input  wire logic [fcds_pkg::FreqW-1:0]  target_freq_hz_i,
  input  wire logic                        out_ready_i,
  input  wire fcds_pkg::cmd_t              cmd_i,
  output fcds_pkg::stat_t                  stat_o,
  output logic                             out_valid_o,
  output logic [fcds_pkg::DivW-1:0]        div_integer_o,
  output logic [fcds_pkg::FracW-1:0]       frac_denominator_o,
  output logic [fcds_pkg::FreqW-1:0]       frac_numerator_o,
  output logic                             numerator_too_wide_o,
  output logic                             zero_target_o
);

  localparam int unsigned W = fcds_pkg::FreqW;
  localparam int unsigned N = fcds_pkg::DivW;

  // a / 63 as (a * ceil(2^(W+6) / 63)) >> (W+6), exact for any W-bit a
  localparam int unsigned RecipW     = W + 1;
  localparam int unsigned RecipShift = W + fcds_pkg::FracW;
  localparam int unsigned ProdW      = W + RecipW;
  localparam logic [RecipW-1:0] RecipMul =
    RecipW'(((64'd1 << RecipShift) + 64'(fcds_pkg::FracSpan) - 64'd1) /
            64'(fcds_pkg::FracSpan));

  logic [W-1:0] base_q, tgt_q, rem_q, y_q, a_q, b_q, d_q;
  logic [N-1:0] n_q;
  logic         zero_q;

  logic [N-1:0] out_n_q;
  logic [fcds_pkg::FracW-1:0] out_a_q;
  logic [W-1:0] out_b_q;
  logic         out_wide_q, out_zero_q, out_valid_q;

  logic         div_start, div_busy, div_done;
  logic [W-1:0] div_dvd, div_dsr, div_quot, div_rem;
  logic [W+N-1:0] cap_rem;
  logic [ProdW-1:0] recip_prod;
  logic [ProdW-RecipShift-1:0] a_div63;

  fcds_div #(.W(W)) u_div (
    .clk_i,
    .rst_ni,
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // remainder when n is capped: base - 255 * target
  assign cap_rem = {{N{1'b0}}, base_q} - ({tgt_q, {N{1'b0}}} - {{N{1'b0}}, tgt_q});

  assign recip_prod = ProdW'(a_q) * ProdW'(RecipMul);
  assign a_div63    = recip_prod[ProdW-1:RecipShift];

  // divider operand select
  always_comb begin
    div_start = 1'b1;
    div_dvd   = '0;
    div_dsr   = '0;
    unique case (cmd_i.op)
      fcds_pkg::OpDivN:   begin div_dvd = base_q; div_dsr = tgt_q;              end
      fcds_pkg::OpEuInit: begin div_dvd = tgt_q;  div_dsr = rem_q;              end
      fcds_pkg::OpEuStep: begin div_dvd = y_q;    div_dsr = div_rem;            end
      fcds_pkg::OpGDone:  begin div_dvd = tgt_q;  div_dsr = y_q;                end
      fcds_pkg::OpADone:  begin div_dvd = rem_q;  div_dsr = y_q;                end
      fcds_pkg::OpDDone:  begin div_dvd = a_q;    div_dsr = d_q;                end
      fcds_pkg::OpA2Done: begin div_dvd = b_q;    div_dsr = d_q;                end
      default:            div_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= fcds_pkg::BaseReset;
    end else if (cfg_valid_i) begin
      base_q <= base_clock_hz_i;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      fcds_pkg::OpLoad: tgt_q <= target_freq_hz_i;
      fcds_pkg::OpSetZero: begin
        n_q    <= '0;
        a_q    <= W'(1);
        b_q    <= '0;
        zero_q <= 1'b1;
      end
      fcds_pkg::OpCapN: begin
        zero_q <= 1'b0;
        if (|div_quot[W-1:N]) begin
          n_q   <= fcds_pkg::DivCap;
          rem_q <= cap_rem[W-1:0];
        end else begin
          n_q   <= div_quot[N-1:0];
          rem_q <= div_rem;
        end
      end
      fcds_pkg::OpEuInit: y_q <= rem_q;
      fcds_pkg::OpEuStep: y_q <= div_rem;
      fcds_pkg::OpADone:  a_q <= div_quot;
      // scale factor a / 63 + 1 from the reduced denominator
      fcds_pkg::OpBDone: begin
        b_q <= div_quot;
        d_q <= W'(a_div63) + W'(1);
      end
      fcds_pkg::OpA2Done: a_q <= div_quot;
      fcds_pkg::OpB2Done: b_q <= div_quot;
      fcds_pkg::OpSetTriv: begin
        a_q <= W'(1);
        b_q <= '0;
      end
      default: ;
    endcase
  end

  // result register, decoupled from the working set
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == fcds_pkg::OpEmit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == fcds_pkg::OpEmit) begin
      out_n_q    <= n_q;
      out_a_q    <= a_q[fcds_pkg::FracW-1:0];
      out_b_q    <= b_q;
      out_wide_q <= b_q > fcds_pkg::FracSpan;
      out_zero_q <= zero_q;
    end
  end

  always_comb begin
    stat_o.tgt_zero     = tgt_q == '0;
    stat_o.n_gt_min     = n_q > fcds_pkg::FracMinN;
    stat_o.rem_zero     = rem_q == '0;
    stat_o.div_done     = div_done;
    stat_o.div_rem_zero = div_rem == '0;
    stat_o.out_free     = !out_valid_q || out_ready_i;
  end

  assign out_valid_o          = out_valid_q;
  assign div_integer_o        = out_n_q;
  assign frac_denominator_o   = out_a_q;
  assign frac_numerator_o     = out_b_q;
  assign numerator_too_wide_o = out_wide_q;
  assign zero_target_o        = out_zero_q;

  `FCDS_ASSERT_NEVER(a_div_start_busy, clk_i, rst_ni, div_start && div_busy)
  `FCDS_ASSERT(a_emit_free, clk_i, rst_ni,
    (cmd_i.op == fcds_pkg::OpEmit) |-> (!out_valid_q || out_ready_i))
  `FCDS_ASSERT(a_denom_nonzero, clk_i, rst_ni, out_valid_q |-> (out_a_q != '0))
  `FCDS_ASSERT(a_zero_defaults, clk_i, rst_ni,
    (out_valid_q && out_zero_q) |-> ((out_n_q == '0) && (out_b_q == '0)))

endmodule

`default_nettype wire

// File: design/fcds_ctrl.sv
// ----------------------------------------------------------------------------
// fcds_ctrl
// Sequencer: steps the datapath through divide, Euclid and scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module fcds_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire fcds_pkg::stat_t stat_i,
  output fcds_pkg::cmd_t       cmd_o
);

  localparam logic [3:0] SIdle = 4'd0;
  localparam logic [3:0] SChk  = 4'd1;
  localparam logic [3:0] SWn   = 4'd2;
  localparam logic [3:0] STst  = 4'd3;
  localparam logic [3:0] SWe   = 4'd4;
  localparam logic [3:0] SWa   = 4'd5;
  localparam logic [3:0] SWb   = 4'd6;
  localparam logic [3:0] SWd   = 4'd7;
  localparam logic [3:0] SWa2  = 4'd8;
  localparam logic [3:0] SWb2  = 4'd9;
  localparam logic [3:0] SFin  = 4'd10;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = fcds_pkg::OpNop;
    unique case (state_q)
      SIdle: if (in_valid_i) begin
        cmd_o.op = fcds_pkg::OpLoad;
        state_d  = SChk;
      end
      SChk: if (stat_i.tgt_zero) begin
        cmd_o.op = fcds_pkg::OpSetZero;
        state_d  = SFin;
      end else begin
        cmd_o.op = fcds_pkg::OpDivN;
        state_d  = SWn;
      end
      SWn: if (stat_i.div_done) begin
        cmd_o.op = fcds_pkg::OpCapN;
        state_d  = STst;
      end
      STst: if (stat_i.n_gt_min && !stat_i.rem_zero) begin
        cmd_o.op = fcds_pkg::OpEuInit;
        state_d  = SWe;
      end else begin
        cmd_o.op = fcds_pkg::OpSetTriv;
        state_d  = SFin;
      end
      SWe: if (stat_i.div_done) begin
        if (stat_i.div_rem_zero) begin
          cmd_o.op = fcds_pkg::OpGDone;
          state_d  = SWa;
        end else begin
          cmd_o.op = fcds_pkg::OpEuStep;
        end
      end
      SWa: if (stat_i.div_done) begin
        cmd_o.op = fcds_pkg::OpADone;
        state_d  = SWb;
      end
      SWb: if (stat_i.div_done) begin
        cmd_o.op = fcds_pkg::OpBDone;
        state_d  = SWd;
      end
      // scale factor is registered; start a / d right away
      SWd: begin
        cmd_o.op = fcds_pkg::OpDDone;
        state_d  = SWa2;
      end
      SWa2: if (stat_i.div_done) begin
        cmd_o.op = fcds_pkg::OpA2Done;
        state_d  = SWb2;
      end
      SWb2: if (stat_i.div_done) begin
        cmd_o.op = fcds_pkg::OpB2Done;
        state_d  = SFin;
      end
      SFin: if (stat_i.out_free) begin
        cmd_o.op = fcds_pkg::OpEmit;
        state_d  = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = state_q == SIdle;

endmodule

`default_nettype wire

// File: design/fractional_clock_divider_solver.sv
// ----------------------------------------------------------------------------
// fractional_clock_divider_solver
// Finds integer divisor n and fraction b/a so that base / (n + b/a) ~ target.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel  : cfg_valid_i/cfg_ready_o with base_clock_hz_i; always ready.
//                  Write only while no request is in flight.
//   in channel   : in_valid_i/in_ready_o with target_freq_hz_i. One request
//                  is worked on at a time; in_ready_o is high when idle.
//   out channel  : out_valid_o/out_ready_i with n, a, b and two flags.
// Work per request: a zero target uses no division, a small or exact divisor
//   one, otherwise 6 + k divisions, k being the Euclid remainder steps
//   (k <= ~43 for 30-bit operands). Every division runs on one shared
//   30-bit restoring divider; the scale a / 63 + 1 is a constant
//   reciprocal multiply.
// Requests: the next one is accepted only after the previous result has been written to the output register.
// Stall: the result sits in its own output register; the next request is
//   accepted and computed meanwhile, and only the final write waits for the
//   register to free up.
// Reset: base clock returns to 80 MHz, no result pending, sequencer idle.
// ----------------------------------------------------------------------------
`default_nettype none

module fractional_clock_divider_solver (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration write
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [fcds_pkg::FreqW-1:0]  base_clock_hz_i,
  // request
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [fcds_pkg::FreqW-1:0]  target_freq_hz_i,
  // result
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [fcds_pkg::DivW-1:0]        div_integer_o,
  output logic [fcds_pkg::FracW-1:0]       frac_denominator_o,
  output logic [fcds_pkg::FreqW-1:0]       frac_numerator_o,
  output logic                             numerator_too_wide_o,
  output logic                             zero_target_o
);

  fcds_pkg::cmd_t  cmd;
  fcds_pkg::stat_t stat;

  // register has no side effects, so writes are never held off
  assign cfg_ready_o = 1'b1;

  // sequencer: owns the request handshake and issues one op per cycle
  fcds_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // datapath: divider, Euclid working set, scaling and result register
  fcds_dp u_dp (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .base_clock_hz_i,
    .target_freq_hz_i,
    .out_ready_i,
    .cmd_i  (cmd),
    .stat_o (stat),
    .out_valid_o,
    .div_integer_o,
    .frac_denominator_o,
    .frac_numerator_o,
    .numerator_too_wide_o,
    .zero_target_o
  );

endmodule

`default_nettype wire
